/* rtl/inv53_pkg.sv */
`timescale 1ns / 1ps

package inv53_pkg;

  localparam int COEF_BITS = 20;
  localparam int LEN_BITS  = 13;
  localparam int MAX_LINE  = 4096;
  localparam int PAIR_BITS = 12;
  // room for the sum of three coefficient-sized terms
  localparam int WIDE_BITS = COEF_BITS + 2;
  localparam int SLOTS     = 3;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef logic signed [WIDE_BITS-1:0] wide_t;
  typedef logic [LEN_BITS-1:0]         len_t;
  typedef logic [PAIR_BITS-1:0]        pair_t;

  // samples produced by one pair, in line order
  typedef struct packed {
    logic [1:0]            count;
    coef_t [SLOTS-1:0]     sample;
    logic  [SLOTS-1:0]     last;
  } push_t;

  function automatic coef_t sat_coef(input wide_t x);
    logic [WIDE_BITS-COEF_BITS:0] top;
    top = x[WIDE_BITS-1:COEF_BITS-1];
    if ((&top) || !(|top)) begin
      return x[COEF_BITS-1:0];
    end else if (x[WIDE_BITS-1]) begin
      return {1'b1, {(COEF_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(COEF_BITS-1){1'b1}}};
    end
  endfunction

endpackage

/* rtl/inv53_lift.sv */
`timescale 1ns / 1ps

module inv53_lift (
  input  logic                   clk,
  input  logic                   rst,
  input  inv53_pkg::len_t        line_length,
  input  logic                   restart,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  inv53_pkg::coef_t       in_low,
  input  inv53_pkg::coef_t       in_high,
  input  logic                   push_ok,
  output inv53_pkg::push_t       push
);
  import inv53_pkg::*;

  logic  full;
  coef_t lo_r;
  coef_t hi_r;
  coef_t prev_high;
  coef_t prev_even;
  pair_t pair_index;

  logic  fire;
  len_t  len_eff;
  len_t  len_plus;
  pair_t pairs;
  logic  final_pair;
  logic  odd_len;
  logic  len_one;
  logic  first;
  coef_t hm;
  coef_t hp;
  wide_t sum_h;
  wide_t diff;
  coef_t even_s;
  logic signed [COEF_BITS:0] sum_e;
  wide_t odd_mid;
  logic signed [COEF_BITS:0] odd_end;
  coef_t odd_mid_s;
  coef_t odd_end_s;
  logic  [PAIR_BITS:0] k_plus;

  assign fire     = full && push_ok;
  assign in_ready = !full || push_ok;

  always_comb begin
    if (line_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (line_length > LEN_BITS'(MAX_LINE)) begin
      len_eff = LEN_BITS'(MAX_LINE);
    end else begin
      len_eff = line_length;
    end
    len_plus   = len_eff + LEN_BITS'(1);
    pairs      = len_plus[LEN_BITS-1:1];
    k_plus     = {1'b0, pair_index} + (PAIR_BITS+1)'(1);
    final_pair = k_plus >= {1'b0, pairs};
    odd_len    = len_eff[0];
    len_one    = len_eff == LEN_BITS'(1);
    first      = pair_index == '0;

    hm = first ? hi_r : prev_high;
    // odd line: the missing high term mirrors the previous one
    hp = (final_pair && odd_len) ? hm : hi_r;
    sum_h  = WIDE_BITS'(hm) + WIDE_BITS'(hp) + WIDE_BITS'(2);
    diff   = WIDE_BITS'(lo_r) - (sum_h >>> 2);
    even_s = sat_coef(diff);

    sum_e     = (COEF_BITS+1)'(prev_even) + (COEF_BITS+1)'(even_s);
    odd_mid   = WIDE_BITS'(prev_high) + WIDE_BITS'(sum_e >>> 1);
    odd_end   = (COEF_BITS+1)'(hi_r) + (COEF_BITS+1)'(even_s);
    odd_mid_s = sat_coef(odd_mid);
    odd_end_s = sat_coef(WIDE_BITS'(odd_end));

    push = '0;
    if (len_one) begin
      push.sample[0] = lo_r;
      push.last[0]   = 1'b1;
      push.count     = 2'd1;
    end else if (first) begin
      push.sample[0] = even_s;
      push.last[0]   = final_pair && odd_len;
      push.sample[1] = odd_end_s;
      push.last[1]   = 1'b1;
      push.count     = (final_pair && !odd_len) ? 2'd2 : 2'd1;
    end else begin
      push.sample[0] = odd_mid_s;
      push.sample[1] = even_s;
      push.last[1]   = final_pair && odd_len;
      push.sample[2] = odd_end_s;
      push.last[2]   = 1'b1;
      push.count     = (final_pair && !odd_len) ? 2'd3 : 2'd2;
    end
    if (!fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full       <= 1'b0;
      pair_index <= '0;
      prev_high  <= '0;
      prev_even  <= '0;
    end else begin
      if (in_ready) begin
        full <= in_valid;
      end
      if (fire) begin
        prev_high  <= len_one ? '0 : hi_r;
        prev_even  <= len_one ? lo_r : even_s;
        pair_index <= (len_one || final_pair) ? '0 : k_plus[PAIR_BITS-1:0];
      end
      if (restart) begin
        pair_index <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lo_r <= in_low;
      hi_r <= in_high;
    end
  end

endmodule

/* rtl/inv53_queue.sv */
`timescale 1ns / 1ps

module inv53_queue (
  input  logic              clk,
  input  logic              rst,
  input  inv53_pkg::push_t  push,
  output logic              push_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output inv53_pkg::coef_t  out_sample,
  output logic              out_last
);
  import inv53_pkg::*;

  coef_t      mem_sample [4];
  logic       mem_last   [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid  = count != 3'd0;
  assign pop        = out_valid && out_ready;
  // a pair may bring three samples, so keep three entries free after the pop
  assign push_ok    = (count <= 3'd1) || (count == 3'd2 && pop);
  assign out_sample = mem_sample[rd_ptr];
  assign out_last   = mem_last[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(push.count) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (2'(i) < push.count) begin
        mem_sample[wr_ptr + 2'(i)] <= push.sample[i];
        mem_last[wr_ptr + 2'(i)]   <= push.last[i];
      end
    end
  end

endmodule

/* rtl/inverse_53_lifting_line.sv */
`timescale 1ns / 1ps

// Inverse reversible 5/3 lifting over one line. Each input request is one
// coefficient pair; the block emits the reconstructed samples in line order,
// saturated to 20 bits, with tlast on the final sample of the line. A pair is
// registered, lifted combinationally and its one to three samples are written
// into a four-entry sample queue; the output port drains one sample a cycle
// while m_tready is high, so the sustained rate is one sample per cycle, set
// by the single output sample port. Writing line_length (1..4096, 0 reads as
// 1, larger values as 4096; reset 2) restarts the line; write it only while
// the block is idle.
module inverse_53_lifting_line (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wdata,     // line_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,       // [19:0] low_coef, [39:20] high_coef
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,       // [19:0] sample, [23:20] zero
  output logic        m_tlast        // last_sample
);
  import inv53_pkg::*;

  len_t  line_length;
  push_t push;
  logic  push_ok;
  coef_t out_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_BITS'(2);
    end else if (cfg_we) begin
      line_length <= cfg_wdata;
    end
  end

  inv53_lift u_lift (
    .clk         (clk),
    .rst         (rst),
    .line_length (line_length),
    .restart     (cfg_we),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_low      (s_tdata[COEF_BITS-1:0]),
    .in_high     (s_tdata[2*COEF_BITS-1:COEF_BITS]),
    .push_ok     (push_ok),
    .push        (push)
  );

  inv53_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ok    (push_ok),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_sample (out_sample),
    .out_last   (m_tlast)
  );

  assign m_tdata = {4'b0, out_sample};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import inv53_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 8;
  localparam int CMAX        = (1 << (COEF_BITS - 1)) - 1;
  localparam int CMIN        = -(1 << (COEF_BITS - 1));

  typedef struct {
    coef_t sample;
    logic  last;
  } sample_exp_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [12:0] cfg_wdata = '0;    // line_length
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata   = '0;    // [19:0] low_coef, [39:20] high_coef
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;           // [19:0] sample, [23:20] zero
  logic        m_tlast;           // last_sample

  sample_exp_t expected_samples[$];
  int          errors     = 0;
  int          cycles     = 0;
  int          pairs_sent = 0;
  bit          send_gaps  = 1'b1;
  bit          recv_gaps  = 1'b1;
  int          hold_left  = 0;

  // predictor state
  len_t        line_len   = len_t'(2);
  pair_t       pair_idx   = '0;
  int          prev_high  = 0;
  int          prev_even  = 0;

  always #5 clk = ~clk;

  inverse_53_lifting_line u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  function automatic coef_t clamp_coef(input int x);
    if (x > CMAX) return coef_t'(CMAX);
    if (x < CMIN) return coef_t'(CMIN);
    return coef_t'(x);
  endfunction

  function void expect_sample(input coef_t s, input logic l);
    sample_exp_t item;
    item.sample = s;
    item.last   = l;
    expected_samples.push_back(item);
  endfunction

  // one pair through the inverse lifting steps; queues the samples it yields
  function void lift_pair(input coef_t lo, input coef_t hi);
    int lo_i, hi_i, len, pairs, hm, hp, e;
    bit fin, odd_len;
    lo_i = lo;
    hi_i = hi;
    len = line_len;
    if (len == 0) len = 1;
    if (len > MAX_LINE) len = MAX_LINE;
    pairs   = (len + 1) / 2;
    fin     = (int'(pair_idx) + 1 >= pairs);
    odd_len = (len % 2) == 1;
    if (len == 1) begin
      expect_sample(lo, 1'b1);
      prev_high = 0;
      prev_even = lo_i;
      pair_idx  = '0;
      return;
    end
    // symmetric extension: high[-1] = high[0], high[n] = high[n-1]
    hm = (pair_idx == 0) ? hi_i : prev_high;
    hp = (fin && odd_len) ? hm : hi_i;
    e  = clamp_coef(lo_i - ((hm + hp + 2) >>> 2));
    if (pair_idx != 0) begin
      expect_sample(clamp_coef(prev_high + ((prev_even + e) >>> 1)), 1'b0);
    end
    expect_sample(coef_t'(e), fin && odd_len);
    if (fin && !odd_len) begin
      expect_sample(clamp_coef(hi_i + e), 1'b1);
    end
    prev_high = hi_i;
    prev_even = e;
    pair_idx  = fin ? pair_t'(0) : pair_t'(pair_idx + 1'b1);
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 7))
      0: return coef_t'(CMAX);
      1: return coef_t'(CMIN);
      2: return coef_t'(int'($urandom_range(0, 8)) - 4);
      3: return coef_t'(int'($urandom_range(0, 2000)) - 1000);
      default: return coef_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 50) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_sample(input coef_t got, input logic got_last);
    sample_exp_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("unexpected sample %0d last %0b", got, got_last));
      return;
    end
    want = expected_samples.pop_front();
    if (got !== want.sample) begin
      report_mismatch($sformatf("sample %0d, expected %0d", got, want.sample));
    end
    if (got_last !== want.last) begin
      report_mismatch($sformatf("last %0b, expected %0b (sample %0d)",
                                got_last, want.last, want.sample));
    end
  endtask

  // valid stays high from one request to the next unless a gap is drawn
  task automatic send_pair(input coef_t lo, input coef_t hi);
    int gap;
    gap = send_gaps ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {hi, lo};
    lift_pair(lo, hi);
    pairs_sent++;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_pairs(input int n);
    for (int i = 0; i < n; i++) send_pair(rand_coef(), rand_coef());
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_line_length(input len_t v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    line_len = v;
    pair_idx = '0;
  endtask

  // four lines at the reset length, saturating both ways
  task automatic test_reset_length();
    send_pair(coef_t'(CMIN), coef_t'(CMAX));
    send_pair(coef_t'(CMAX), coef_t'(CMIN));
    send_pair(coef_t'(0), coef_t'(0));
    send_pair(coef_t'(-1), coef_t'(1));
  endtask

  // single-sample lines; zero reads as one
  task automatic test_line_of_one();
    set_line_length(len_t'(1));
    send_pair(coef_t'(CMAX), coef_t'(CMIN));
    send_pair(coef_t'(CMIN), coef_t'(CMAX));
    send_pair(coef_t'(-1), coef_t'(0));
    set_line_length(len_t'(0));
    send_pair(coef_t'(5), coef_t'(-7));
    send_pair(coef_t'(CMIN), coef_t'(CMIN));
  endtask

  // odd and even endings, extremes alternated
  task automatic test_short_lines();
    bit flip;
    flip = 1'b0;
    for (int len = 3; len <= 5; len++) begin
      set_line_length(len_t'(len));
      for (int k = 0; k < (len + 1) / 2; k++) begin
        send_pair(flip ? coef_t'(CMIN) : coef_t'(CMAX),
                  flip ? coef_t'(CMAX) : coef_t'(CMIN));
        flip = ~flip;
      end
      flip = ~flip;
    end
  endtask

  // all-ones write clamps to the longest line; each write restarts it
  task automatic test_max_line();
    send_gaps = 1'b0;
    set_line_length(len_t'(13'h1FFF));
    send_pairs(16);
    set_line_length(len_t'(MAX_LINE));
    send_pairs(12);
    set_line_length(len_t'(MAX_LINE - 1));
    send_pairs(20);
    send_gaps = 1'b1;
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    set_line_length(len_t'(9));
    send_gaps = 1'b0;
    hold_left = 400;
    send_pairs(40);
    send_gaps = 1'b1;
  endtask

  task automatic test_random_lines();
    int len, eff, reps, n, r;
    while (pairs_sent < 330) begin
      r = $urandom_range(0, 19);
      if (r < 14) len = $urandom_range(1, 16);
      else if (r < 19) len = $urandom_range(17, 64);
      else len = 0;
      set_line_length(len_t'(len));
      eff  = (len == 0) ? 1 : len;
      reps = $urandom_range(1, 3);
      for (int i = 0; i < reps; i++) begin
        if (pairs_sent >= 330) break;
        send_gaps = ($urandom_range(0, 4) != 0);
        recv_gaps = ($urandom_range(0, 4) != 0);
        n = (eff + 1) / 2;
        // now and then cut a line short; the next write restarts it
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
        send_pairs(n);
      end
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin : sample_checker
    int stall;
    stall = 0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        check_sample(m_tdata[COEF_BITS-1:0], m_tlast);
        stall = recv_gaps ? $urandom_range(0, 10) : 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_length();
    test_line_of_one();
    test_short_lines();
    test_max_line();
    test_backpressure();
    test_random_lines();
    wait_idle();
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
